>>> sv/rws_pkg.sv
// ----------------------------------------------------------------------------
// rws_pkg
// Shared types and codes for the roulette wheel selector: request and
// result structs, request kinds, selection modes and controller states.
// ----------------------------------------------------------------------------
package rws_pkg;

  localparam int POP_MAX_DEF = 256;

  // request kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // selection modes; the unused code behaves as maximize
  localparam logic [1:0] MODE_RANK = 2'd0;
  localparam logic [1:0] MODE_MAX  = 2'd1;
  localparam logic [1:0] MODE_MIN  = 2'd2;

  // bit-serial reciprocal: one quotient bit per cycle over a 33-bit dividend
  localparam logic [5:0] DIV_STEPS = 6'd32;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] fitness;
    logic [15:0] random_fraction;
  } in_req_t;

  typedef struct packed {
    logic [7:0] chosen_index;
    logic       status;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PROD,
    ST_THRESH,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage

>>> sv/roulette_wheel_selector.sv
// ----------------------------------------------------------------------------
// roulette_wheel_selector
// Fitness-proportionate selection over a weight memory: loads store one
// weight each, draws walk the running sum against a scaled threshold.
// ----------------------------------------------------------------------------
// Load: a direct write in rank and maximize mode and for fitness 0 or 1; in
//   minimize mode otherwise the bit-serial reciprocal divider runs first.
// Clear zeroes the entry count and total. Draw: the walk takes one weight per cycle,
//   stored or n-k in rank mode, from index 0 up to the chosen index k, bounded by the n
//   loaded entries; an empty population skips the walk and answers with status set.
// Reset: mode rank, entry count and total zero; memory contents undefined.
module roulette_wheel_selector #(
  parameter int POP_MAX = rws_pkg::POP_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  rws_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rws_pkg::out_rsp_t out_data
);

  localparam int IDX_W = (POP_MAX > 1) ? $clog2(POP_MAX) : 1;
  localparam int CNT_W = $clog2(POP_MAX + 1);
  localparam int TOT_W = 32 + IDX_W;
  localparam int PRD_W = 2 * CNT_W;

  rws_pkg::state_t state, state_next;

  logic [1:0]        mode;
  logic [CNT_W-1:0]  count;
  logic [TOT_W-1:0]  total;
  logic [31:0]       fit;
  logic [15:0]       frac;
  logic              empty;
  logic [IDX_W-1:0]  k;
  logic [TOT_W-1:0]  acc;
  logic [TOT_W-1:0]  thr;
  logic [PRD_W-1:0]  rank_prod;
  logic [31:0]       div_rem;
  logic [31:0]       div_q;
  logic [5:0]        div_cnt;

  logic [31:0]       mem [POP_MAX];
  logic [31:0]       rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic              we;
  logic [31:0]       wr_data;

  logic              in_acc;
  logic              full;
  logic              is_min;
  logic              needs_div;
  logic              out_free;

  logic [32:0]       div_shift;
  logic              div_ge;
  logic [31:0]       div_rem_next;
  logic [31:0]       div_q_next;

  logic [CNT_W:0]    kp1;
  logic [TOT_W-1:0]  term;
  logic [TOT_W-1:0]  acc_cur;
  logic              walk_go;
  logic [TOT_W-1:0]  sel_total;
  logic [TOT_W+15:0] thr_prod;

  assign in_acc    = in_valid && in_ready;
  assign full      = (count == CNT_W'(POP_MAX));
  assign is_min    = (mode == rws_pkg::MODE_MIN);
  assign needs_div = is_min && (in_data.fitness > 32'd1);
  assign out_free  = !out_valid || out_ready;

  // restoring division of 2^32 by the fitness
  assign div_shift    = {div_rem, (div_cnt == rws_pkg::DIV_STEPS)};
  assign div_ge       = (div_shift >= {1'b0, fit});
  assign div_rem_next = div_ge ? 32'(div_shift - {1'b0, fit}) : div_shift[31:0];
  assign div_q_next   = {div_q[30:0], div_ge};

  // walk: rank mode weighs rank k by n-k, otherwise the stored weight
  assign kp1       = (CNT_W+1)'(k) + 1'b1;
  assign term      = (mode == rws_pkg::MODE_RANK) ? TOT_W'(count - CNT_W'(k))
                                                  : TOT_W'(rd_data);
  assign acc_cur   = acc + term;
  assign walk_go   = (acc_cur < thr) && (kp1 < (CNT_W+1)'(count));
  assign sel_total = (mode == rws_pkg::MODE_RANK) ? TOT_W'(rank_prod >> 1) : total;
  assign thr_prod  = (TOT_W+16)'(frac) * (TOT_W+16)'(sel_total);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rws_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.kind == rws_pkg::KIND_LOAD) begin
            if (!full && needs_div) state_next = rws_pkg::ST_DIV;
          end else if (in_data.kind == rws_pkg::KIND_DRAW) begin
            state_next = (count == '0) ? rws_pkg::ST_DONE : rws_pkg::ST_PROD;
          end
        end
      end
      rws_pkg::ST_DIV:    if (div_cnt == '0) state_next = rws_pkg::ST_IDLE;
      rws_pkg::ST_PROD:   state_next = rws_pkg::ST_THRESH;
      rws_pkg::ST_THRESH: state_next = rws_pkg::ST_WALK;
      rws_pkg::ST_WALK:   if (!walk_go) state_next = rws_pkg::ST_DONE;
      rws_pkg::ST_DONE:   if (out_free) state_next = rws_pkg::ST_IDLE;
      default:            state_next = rws_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    we       = 1'b0;
    wr_data  = in_data.fitness;
    rd_addr  = '0;
    unique case (state)
      rws_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc && (in_data.kind == rws_pkg::KIND_LOAD) && !full && !needs_div) begin
          we      = 1'b1;
          wr_data = is_min ? 32'hFFFF_FFFF : in_data.fitness;
        end
      end
      rws_pkg::ST_DIV: begin
        if (div_cnt == '0) begin
          we      = 1'b1;
          wr_data = div_q_next;
        end
      end
      rws_pkg::ST_WALK: rd_addr = IDX_W'(kp1);
      default: ;
    endcase
  end

  // weight memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[IDX_W'(count)] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rws_pkg::ST_IDLE;
      mode      <= rws_pkg::MODE_RANK;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) mode <= cfg_wr_data;
      if (we) begin
        count <= count + 1'b1;
        total <= total + TOT_W'(wr_data);
      end else if (in_acc && (in_data.kind == rws_pkg::KIND_CLEAR)) begin
        count <= '0;
        total <= '0;
      end
      if ((state == rws_pkg::ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      rws_pkg::ST_IDLE: begin
        fit     <= in_data.fitness;
        frac    <= in_data.random_fraction;
        empty   <= (count == '0);
        k       <= '0;
        div_rem <= '0;
        div_q   <= '0;
        div_cnt <= rws_pkg::DIV_STEPS;
      end
      rws_pkg::ST_DIV: begin
        div_rem <= div_rem_next;
        div_q   <= div_q_next;
        div_cnt <= div_cnt - 1'b1;
      end
      rws_pkg::ST_PROD: begin
        rank_prod <= PRD_W'(count) * (PRD_W'(count) + 1'b1);
      end
      rws_pkg::ST_THRESH: begin
        thr <= thr_prod[TOT_W+15:16];
        acc <= '0;
        k   <= '0;
      end
      rws_pkg::ST_WALK: begin
        if (walk_go) begin
          k   <= IDX_W'(kp1);
          acc <= acc_cur;
        end
      end
      rws_pkg::ST_DONE: begin
        if (out_free) begin
          out_data.chosen_index <= empty ? 8'd0 : 8'(k);
          out_data.status       <= empty;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(POP_MAX))
    else $error("entry count beyond population size");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (in_data.kind == rws_pkg::KIND_CLEAR)) |=> (count == '0) && (total == '0))
    else $error("clear left entries behind");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == rws_pkg::ST_WALK) |-> ((CNT_W+1)'(k) < (CNT_W+1)'(count)))
    else $error("walk index past loaded entries");

  a_div_room: assert property (@(posedge clk) disable iff (rst)
    (state == rws_pkg::ST_DIV) |-> !full)
    else $error("reciprocal started on a full population");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roulette_wheel_selector testbench
// The table of directed requests runs first: empty, single and all-zero
// wheels, both ends of the fields, every kind and every mode. Random phases
// follow, each with draws and zero or more loads. Each phase reprograms the
// mode; phases 3 and 10 fill the wheel past capacity. Every draw is checked
// against the wheel model or a typed row, and both handshakes idle randomly.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] KIND_SPARE = 2'd3;  // unused kind, dropped by the block
  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused mode, acts as maximize
  localparam int ITEMS          = 1100;
  localparam int CALM_TAIL      = 120;
  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 40;
  localparam int DRAIN_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    bit                is_cfg;
    logic [1:0]        mode;
    rws_pkg::in_req_t  req;
    bit                typed;
    rws_pkg::out_rsp_t want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [1:0]        cfg_wr_data = 2'd0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  rws_pkg::in_req_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  rws_pkg::out_rsp_t out_data;

  // wheel model
  logic [31:0] wheel_weights [rws_pkg::POP_MAX_DEF];
  int unsigned wheel_count = 0;
  logic [63:0] wheel_total = '0;
  logic [1:0]  wheel_mode = rws_pkg::MODE_RANK;

  rws_pkg::out_rsp_t pending_picks [$];
  rws_pkg::out_rsp_t oldest;
  dir_row_t          dir_rows [$];

  bit calm = 1'b0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  int req_count = 0;
  int draw_count = 0;
  int load_count = 0;
  int clear_count = 0;
  int full_drops = 0;
  int max_pop = 0;
  int mode_writes = 0;
  int checked = 0;
  int fail_count = 0;

  roulette_wheel_selector DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  always #5 clk = ~clk;

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Advance the wheel model by one request; draws yield the predicted pick.
  task automatic spin_wheel(input rws_pkg::in_req_t r, output bit has_pick,
                            output rws_pkg::out_rsp_t pick);
    logic [31:0] w;
    logic [63:0] span;
    logic [63:0] thr;
    logic [63:0] acc;
    int unsigned k;
    has_pick = 1'b0;
    pick = '0;
    case (r.kind)
      rws_pkg::KIND_LOAD: begin
        load_count++;
        if (wheel_count >= rws_pkg::POP_MAX_DEF) begin
          full_drops++;
        end else begin
          if (wheel_mode == rws_pkg::MODE_MIN)
            w = (r.fitness <= 32'd1) ? '1 : 32'((64'd1 << 32) / 64'(r.fitness));
          else
            w = r.fitness;
          wheel_weights[wheel_count] = w;
          wheel_count++;
          wheel_total += 64'(w);
          if (wheel_count > max_pop) max_pop = wheel_count;
        end
      end
      rws_pkg::KIND_CLEAR: begin
        clear_count++;
        wheel_count = 0;
        wheel_total = '0;
      end
      rws_pkg::KIND_DRAW: begin
        draw_count++;
        has_pick = 1'b1;
        if (wheel_count == 0) begin
          pick.status = 1'b1;
        end else if (wheel_count > 1) begin
          if (wheel_mode == rws_pkg::MODE_RANK) begin
            span = 64'(wheel_count) * 64'(wheel_count + 1) / 64'd2;
            acc = 64'(wheel_count);
          end else begin
            span = wheel_total;
            acc = 64'(wheel_weights[0]);
          end
          thr = (64'(r.random_fraction) * span) >> 16;
          k = 0;
          while (acc < thr && k + 1 < wheel_count) begin
            k++;
            acc += (wheel_mode == rws_pkg::MODE_RANK) ? 64'(wheel_count - k)
                                                      : 64'(wheel_weights[k]);
          end
          pick.chosen_index = k[7:0];
        end
      end
      default: ;
    endcase
  endtask

  // Offer one request from a falling edge and return on the falling edge after
  // acceptance, leaving valid high unless an idle burst follows.
  task automatic send_req(input logic [1:0] kind, input logic [31:0] fit,
                          input logic [15:0] frac, input bit typed = 1'b0,
                          input rws_pkg::out_rsp_t want = '0);
    rws_pkg::in_req_t  r;
    bit                has_pick;
    rws_pkg::out_rsp_t pick;
    r = '{kind, fit, frac};
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    spin_wheel(r, has_pick, pick);
    if (has_pick) pending_picks.push_back(typed ? want : pick);
    if (kind != KIND_SPARE) req_count++;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  // Drop valid, wait out every result plus the slowest silent load.
  task automatic settle_wheel();
    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    wheel_mode = m;
    mode_writes++;
  endtask

  function automatic dir_row_t step_row(input logic [1:0] kind, input logic [31:0] fit,
                                        input logic [15:0] frac, input bit typed = 1'b0,
                                        input logic [7:0] idx = 8'd0, input logic st = 1'b0);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.mode = rws_pkg::MODE_RANK;
    row.req = '{kind, fit, frac};
    row.typed = typed;
    row.want = '{idx, st};
    return row;
  endfunction

  function automatic dir_row_t mode_row(input logic [1:0] m);
    dir_row_t row;
    row = step_row(KIND_SPARE, '0, '0);
    row.is_cfg = 1'b1;
    row.mode = m;
    return row;
  endfunction

  function automatic logic [31:0] pick_fitness();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hFFFF_FFFF;
      3: return 32'($urandom_range(0, 32'h3_FFFF));
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_fraction();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_picks.size() == 0) begin
        note_failure($sformatf("unexpected result index %0d status %0d",
                               out_data.chosen_index, out_data.status));
      end else begin
        oldest = pending_picks.pop_front();
        checked++;
        if (out_data.chosen_index !== oldest.chosen_index ||
            out_data.status !== oldest.status)
          note_failure($sformatf(
            "result %0d: expected index %0d status %0d, got index %0d status %0d",
            checked, oldest.chosen_index, oldest.status,
            out_data.chosen_index, out_data.status));
      end
    end
  end

  // watchdog: count cycles in which neither channel moves a request
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d results outstanding",
               idle_cycles, pending_picks.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase;
    int n;
    bit big;
    logic [1:0] m;

    // empty, single, all-zero and saturated wheels across the modes
    dir_rows.push_back(step_row(rws_pkg::KIND_DRAW, 32'h0, 16'h0, 1'b1, 8'd0, 1'b1));
    dir_rows.push_back(step_row(rws_pkg::KIND_LOAD, 32'hFFFF_FFFF, 16'h0));
    dir_rows.push_back(step_row(rws_pkg::KIND_DRAW, 32'h0, 16'hFFFF, 1'b1, 8'd0, 1'b0));
    dir_rows.push_back(step_row(rws_pkg::KIND_LOAD, 32'h0, 16'h0));
    dir_rows.push_back(step_row(rws_pkg::KIND_LOAD, 32'h5, 16'h0));
    dir_rows.push_back(step_row(rws_pkg::KIND_DRAW, 32'h0, 16'h0, 1'b1, 8'd0, 1'b0));
    dir_rows.push_back(step_row(rws_pkg::KIND_DRAW, 32'h0, 16'hFFFF));
    dir_rows.push_back(step_row(KIND_SPARE, 32'hA5A5_5A5A, 16'h5AA5));
    dir_rows.push_back(step_row(rws_pkg::KIND_CLEAR, 32'h0, 16'h0));
    dir_rows.push_back(step_row(rws_pkg::KIND_DRAW, 32'h0, 16'h1234, 1'b1, 8'd0, 1'b1));
    dir_rows.push_back(mode_row(rws_pkg::MODE_MAX));
    dir_rows.push_back(step_row(rws_pkg::KIND_LOAD, 32'h0, 16'h0));
    dir_rows.push_back(step_row(rws_pkg::KIND_LOAD, 32'h0, 16'h0));
    dir_rows.push_back(step_row(rws_pkg::KIND_DRAW, 32'h0, 16'hFFFF, 1'b1, 8'd0, 1'b0));
    dir_rows.push_back(step_row(rws_pkg::KIND_LOAD, 32'hFFFF_FFFF, 16'h0));
    dir_rows.push_back(step_row(rws_pkg::KIND_LOAD, 32'h0001_0000, 16'h0));
    dir_rows.push_back(step_row(rws_pkg::KIND_DRAW, 32'h0, 16'h8000));
    dir_rows.push_back(mode_row(rws_pkg::MODE_MIN));
    dir_rows.push_back(step_row(rws_pkg::KIND_CLEAR, 32'h0, 16'h0));
    dir_rows.push_back(step_row(rws_pkg::KIND_LOAD, 32'h0, 16'h0));
    dir_rows.push_back(step_row(rws_pkg::KIND_LOAD, 32'h1, 16'h0));
    dir_rows.push_back(step_row(rws_pkg::KIND_LOAD, 32'h2, 16'h0));
    dir_rows.push_back(step_row(rws_pkg::KIND_LOAD, 32'hFFFF_FFFF, 16'h0));
    dir_rows.push_back(step_row(rws_pkg::KIND_DRAW, 32'h0, 16'hFFFF));
    dir_rows.push_back(step_row(rws_pkg::KIND_DRAW, 32'h0, 16'h0, 1'b1, 8'd0, 1'b0));
    // stored reciprocals stay as they are when the mode changes
    dir_rows.push_back(mode_row(MODE_SPARE));
    dir_rows.push_back(step_row(rws_pkg::KIND_LOAD, 32'h7, 16'h0));
    dir_rows.push_back(step_row(rws_pkg::KIND_DRAW, 32'h0, 16'hC000));

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle_wheel();
        write_mode(dir_rows[i].mode);
      end else begin
        send_req(dir_rows[i].req.kind, dir_rows[i].req.fitness,
                 dir_rows[i].req.random_fraction, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    phase = 0;
    while (req_count < ITEMS) begin
      settle_wheel();
      m = (phase % 5 == 4) ? 2'($urandom_range(0, 3)) : 2'(phase % 4);
      write_mode(m);
      calm = (req_count >= ITEMS - CALM_TAIL);
      case ($urandom_range(0, 2))
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 10; stall_pct = 10; end
        default: begin gap_pct = 35; stall_pct = 30; end
      endcase
      big = (phase == 3 || phase == 10);
      if (big)
        n = $urandom_range(257, 262);
      else if ($urandom_range(0, 3) == 0)
        n = $urandom_range(13, 40);
      else
        n = $urandom_range(0, 12);
      // keep the old entries now and then so a mode change meets stored weights
      if ($urandom_range(0, 3) != 0)
        send_req(rws_pkg::KIND_CLEAR, 32'($urandom), 16'($urandom));
      for (int i = 0; i < n; i++) begin
        send_req(rws_pkg::KIND_LOAD, pick_fitness(), 16'($urandom));
        if ($urandom_range(0, 2) == 0)
          send_req(rws_pkg::KIND_DRAW, 32'($urandom), pick_fraction());
        if ($urandom_range(0, 19) == 0) send_req(KIND_SPARE, 32'($urandom), 16'($urandom));
        if (!big && $urandom_range(0, 29) == 0)
          send_req(rws_pkg::KIND_CLEAR, 32'($urandom), 16'($urandom));
      end
      // hold the result side so the block backs up into its input
      if (phase == 2) hold_asked++;
      repeat ((phase == 2) ? 12 : $urandom_range(2, 8))
        send_req(rws_pkg::KIND_DRAW, 32'($urandom), pick_fraction());
      phase++;
    end

    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_picks.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_picks.size()));

    $display("Ran %0d requests over %0d phases: %0d loads (%0d dropped at full),",
             req_count, phase, load_count, full_drops);
    $display("%0d draws, %0d clears; checked %0d results, %0d mode writes,",
             draw_count, clear_count, checked, mode_writes);
    $display("largest wheel %0d entries, %0d failures.", max_pop, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
